FILE: src/rist_pkg.sv
// Package with the word types, command codes and microstep mode tables of the indexer.
`timescale 1ns / 1ps

package rist_pkg;

   // Widths that the interface fixes.
   localparam int SLOT_FIELD_W = 4;
   localparam int MODE_W       = 3;
   localparam int PINS_W       = 3;
   localparam int STEPS_W      = 9;
   localparam int CNT_W        = 12;

   // Command codes carried by an input word.
   localparam logic CMD_MOVE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Microstep mode codes.
   localparam logic [MODE_W-1:0] MODE_FULL      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HALF      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_QUARTER   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EIGHTH    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SIXTEENTH = 3'd5;

   // Input word.
   typedef struct packed {
      logic                    command;
      logic [SLOT_FIELD_W-1:0] target_slot;
   } req_type;

   // Result word.
   typedef struct packed {
      logic                    dir_level;
      logic                    enable_level;
      logic                    pulsing;
      logic [SLOT_FIELD_W-1:0] position_now;
      logic [PINS_W-1:0]       microstep_pins;
      logic                    move_done;
   } rsp_type;

   // Step pulses per slot for a mode; unknown modes behave as half step.
   function automatic logic [STEPS_W-1:0] steps_per_slot(input logic [MODE_W-1:0] mode);
      logic [STEPS_W-1:0] steps;
      unique case (mode)
         MODE_FULL:      steps = 9'd13;
         MODE_QUARTER:   steps = 9'd100;
         MODE_EIGHTH:    steps = 9'd200;
         MODE_SIXTEENTH: steps = 9'd400;
         default:        steps = 9'd50;
      endcase
      return steps;
   endfunction

   // Microstep select pin levels (bit0 MS1, bit1 MS2, bit2 MS3) for a mode.
   function automatic logic [PINS_W-1:0] pin_levels(input logic [MODE_W-1:0] mode);
      logic [PINS_W-1:0] pins;
      unique case (mode)
         MODE_FULL:      pins = 3'b000;
         MODE_QUARTER:   pins = 3'b010;
         MODE_EIGHTH:    pins = 3'b011;
         MODE_SIXTEENTH: pins = 3'b111;
         default:        pins = 3'b001;
      endcase
      return pins;
   endfunction

endpackage

FILE: src/rotary_indexer_stepper_control.sv
// Top level of the rotary indexer controller: move and pulse handling with a registered result.
`timescale 1ns / 1ps

// Rotary indexer controller for a step/direction stepper driver. Each input word is
// either a move command (go to target_slot by the shorter way round the ring, with
// exactly half the ring going forward) or a pulse-finished tick. Every accepted word
// yields one result word in the output register in the following cycle, and a new word is
// accepted every cycle while the result is taken or the output register is empty; the
// rate is set by the single state update per cycle. The microstep mode register is
// written through csr_wr_en / csr_wr_data and applies to the next word.
module rotary_indexer_stepper_control #(
   parameter int SLOT_COUNT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  rist_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output rist_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [rist_pkg::MODE_W-1:0]     csr_wr_data
);

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int VAL_W  = ((SLOT_W > rist_pkg::SLOT_FIELD_W) ? SLOT_W
                                                               : rist_pkg::SLOT_FIELD_W) + 1;
   localparam int PROD_W = SLOT_W + rist_pkg::STEPS_W;
   localparam int CMP_W  = (PROD_W > rist_pkg::CNT_W) ? PROD_W : rist_pkg::CNT_W;
   localparam logic [VAL_W-1:0] RING = VAL_W'(SLOT_COUNT);
   localparam logic [VAL_W-1:0] HALF = VAL_W'(SLOT_COUNT / 2);

   // State registers.
   logic [rist_pkg::MODE_W-1:0] step_mode_ff;
   logic [SLOT_W-1:0]           current_ff, current_in;
   logic [SLOT_W-1:0]           goal_ff, goal_in;
   logic [rist_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0]           travel_ff, travel_in;
   logic                        dir_ff, dir_in;
   logic                        enable_ff, enable_in;
   logic                        running_ff, running_in;
   logic                        rsp_valid_ff;
   rist_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   logic                        req_fire;
   logic [VAL_W-1:0]            target_mod;
   logic [VAL_W-1:0]            fwd;
   logic [rist_pkg::CNT_W-1:0]  count_inc;
   logic [PROD_W-1:0]           goal_count;
   logic                        done;

   // The output register parts the two sides; a word enters when it is free or drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Target reduced into the ring and forward distance from the present slot.
   always_comb begin
      target_mod = VAL_W'(req_data.target_slot);
      for (int i = 0; i < 3; i++) begin
         if (target_mod >= RING) begin
            target_mod = target_mod - RING;
         end
      end
      if (target_mod >= VAL_W'(current_ff)) begin
         fwd = target_mod - VAL_W'(current_ff);
      end else begin
         fwd = target_mod + RING - VAL_W'(current_ff);
      end
   end

   // Pulse count and the count at which the move completes.
   assign count_inc  = count_ff + rist_pkg::CNT_W'(1);
   assign goal_count = PROD_W'(travel_ff) * PROD_W'(rist_pkg::steps_per_slot(step_mode_ff));

   // Next state and the result word.
   always_comb begin
      current_in = current_ff;
      goal_in    = goal_ff;
      count_in   = count_ff;
      travel_in  = travel_ff;
      dir_in     = dir_ff;
      enable_in  = enable_ff;
      running_in = running_ff;
      done       = 1'b0;

      if (req_data.command == rist_pkg::CMD_MOVE) begin
         goal_in   = target_mod[SLOT_W-1:0];
         count_in  = '0;
         enable_in = 1'b0;
         if (fwd == '0) begin
            travel_in  = '0;
            running_in = 1'b0;
         end else if (fwd <= HALF) begin
            dir_in     = 1'b0;
            travel_in  = fwd[SLOT_W-1:0];
            running_in = 1'b1;
         end else begin
            dir_in     = 1'b1;
            travel_in  = SLOT_W'(RING - fwd);
            running_in = 1'b1;
         end
      end else if (running_ff) begin
         count_in = count_inc;
         if (CMP_W'(count_inc) == CMP_W'(goal_count)) begin
            running_in = 1'b0;
            enable_in  = 1'b1;
            current_in = goal_ff;
            done       = 1'b1;
         end
      end

      rsp_data_in.dir_level      = dir_in;
      rsp_data_in.enable_level   = enable_in;
      rsp_data_in.pulsing        = running_in;
      rsp_data_in.position_now   = rist_pkg::SLOT_FIELD_W'(current_in);
      rsp_data_in.microstep_pins = rist_pkg::pin_levels(step_mode_ff);
      rsp_data_in.move_done      = done;
   end

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_mode_ff <= rist_pkg::MODE_HALF;
      end else if (csr_wr_en) begin
         step_mode_ff <= csr_wr_data;
      end
   end

   // Positioning state, updated once per accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= SLOT_W'(1 % SLOT_COUNT);
         goal_ff    <= '0;
         count_ff   <= '0;
         travel_ff  <= '0;
         dir_ff     <= 1'b0;
         enable_ff  <= 1'b1;
         running_ff <= 1'b0;
      end else if (req_fire) begin
         current_ff <= current_in;
         goal_ff    <= goal_in;
         count_ff   <= count_in;
         travel_ff  <= travel_in;
         dir_ff     <= dir_in;
         enable_ff  <= enable_in;
         running_ff <= running_in;
      end
   end

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
